// File: sv/vector_step_toward_target_defines.svh
// Assertion macros shared by the vector step block.
`ifndef VECTOR_STEP_TOWARD_TARGET_DEFINES_SVH
`define VECTOR_STEP_TOWARD_TARGET_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define VSTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vstt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vstt: next-cycle check failed");

`else

`define VSTT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define VSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/vstt_pkg.sv
package vstt_pkg;

    // Field widths.
    localparam int ENT_W   = 8;
    localparam int POS_W   = 24;
    localparam int SPEED_W = 16;
    localparam int TICKS_W = 8;

    // A coordinate difference needs one bit more than a position.
    localparam int MAG_W  = POS_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int CNT_W  = $clog2(MAG_W);

    localparam logic [CNT_W-1:0]  LAST_ITER = CNT_W'(MAG_W - 1);
    localparam logic [PROD_W-1:0] ARRIVE_SQ = PROD_W'(563 * 563);
    localparam logic [MAG_W-1:0]  ONE_PIXEL = MAG_W'(256);

    // Request opcodes.
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Status of one serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: sv/vstt_mul.sv
module vstt_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vstt_pkg::mag_t      a,
    input  vstt_pkg::mag_t      b,
    output vstt_pkg::prod_t     prod,
    output vstt_pkg::unit_stat_t stat
);
    import vstt_pkg::*;

    prod_t            acc_reg;
    prod_t            acc_next;
    prod_t            mcand_reg;
    mag_t             mplier_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Shift-and-add: one multiplier bit per cycle.
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// File: sv/vstt_div.sv
module vstt_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vstt_pkg::prod_t     num,
    input  vstt_pkg::mag_t      den,
    output vstt_pkg::mag_t      quot,
    output vstt_pkg::unit_stat_t stat
);
    import vstt_pkg::*;

    // Restoring division, one quotient bit per cycle. The upper half of the
    // dividend must be below the divisor, so the quotient fits in MAG_W bits.
    mag_t             rem_reg;
    mag_t             rem_next;
    mag_t             low_reg;
    mag_t             den_reg;
    mag_t             quot_reg;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             ge;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    assign trial    = {rem_reg, low_reg[MAG_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num[PROD_W-1:MAG_W];
            low_reg  <= num[MAG_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[MAG_W-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// File: sv/vstt_sqrt.sv
module vstt_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vstt_pkg::prod_t     n,
    output vstt_pkg::mag_t      root,
    output vstt_pkg::unit_stat_t stat
);
    import vstt_pkg::*;

    // Digit-by-digit floor square root: two radicand bits per cycle.
    localparam int REM_W = MAG_W + 2;
    localparam int SH_W  = REM_W + 2;

    prod_t            rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    mag_t             root_reg;
    logic [SH_W-1:0]  shifted;
    logic [SH_W-1:0]  trial;
    logic [SH_W-1:0]  diff;
    logic             ge;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    assign shifted  = {rem_reg, rad_reg[PROD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign ge       = shifted >= trial;
    assign diff     = shifted - trial;
    assign rem_next = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= n;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= {root_reg[MAG_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// File: sv/vector_step_toward_target.sv
// Moves entities toward a target in Q8 fixed point, one request at a time.
// The input channel (in_valid/in_ready) carries a request: a load writes the
// position of one entry of the position table, a step moves that entry
// toward target_x/target_y by speed*ticks/TICK_RATE, snapping onto the
// target when it lies within the arrival radius. Every request returns one
// result on the output channel (out_valid/out_ready) with the new position.
// A step request makes eight passes through the bit-serial multiplier,
// divider and square root unit, which handle one bit (two radicand bits
// for the root) per cycle. A step that lands within the arrival radius
// stops after three passes. in_ready is high only while no request is in
// progress and rises in the cycle the result appears, so a new request is
// taken only once the previous result has appeared.
// The finished result sits in an output register, so the next request is
// taken while it still waits; a stalled receiver holds back only the
// completion of that next request.
// Reset clears the control state and empties the output register; the
// position table is not cleared and each entry must be loaded before it is
// stepped.
`include "vector_step_toward_target_defines.svh"

module vector_step_toward_target #(
    parameter int ENTITIES  = 256,
    parameter int TICK_RATE = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [vstt_pkg::ENT_W-1:0]           entity,
    input  logic signed [vstt_pkg::POS_W-1:0]    target_x,
    input  logic signed [vstt_pkg::POS_W-1:0]    target_y,
    input  logic [vstt_pkg::SPEED_W-1:0]         speed,
    input  logic [vstt_pkg::TICKS_W-1:0]         ticks,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [vstt_pkg::ENT_W-1:0]           entity_out,
    output logic signed [vstt_pkg::POS_W-1:0]    new_x,
    output logic signed [vstt_pkg::POS_W-1:0]    new_y,
    output logic                                 arrived,
    output logic                                 facing_set,
    output logic                                 facing_left
);
    import vstt_pkg::*;

    localparam int IDX_W = $clog2(ENTITIES);
    localparam int RED_W = 18;

    // Sequencer states. Each wait state runs one serial pass (divider and root
    // together in S_WROOT) and starts any next pass in the cycle it reports done.
    typedef enum logic [13:0] {
        S_IDLE   = 14'd1,
        S_INDEX  = 14'd2,
        S_READ   = 14'd4,
        S_DIFF   = 14'd8,
        S_SQX    = 14'd16,
        S_WSQX   = 14'd32,
        S_WSQY   = 14'd64,
        S_WSPD   = 14'd128,
        S_WROOT  = 14'd256,
        S_WMX    = 14'd512,
        S_WDX    = 14'd1024,
        S_WMY    = 14'd2048,
        S_WDY    = 14'd4096,
        S_FINISH = 14'd8192
    } state_t;

    // Reduces an entity number modulo the table depth with at most eight
    // conditional subtractions of shifted copies of the depth.
    function automatic logic [IDX_W-1:0] entity_slot(input logic [ENT_W-1:0] e);
        logic [RED_W-1:0] r;
        r = RED_W'(e);
        for (int i = ENT_W - 1; i >= 0; i--)
        begin
            if (r >= (RED_W'(ENTITIES) << i))
            begin
                r = r - (RED_W'(ENTITIES) << i);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    // Captured request.
    logic             op_reg;
    logic [ENT_W-1:0] ent_reg;
    logic [POS_W-1:0] tx_reg;
    logic [POS_W-1:0] ty_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [IDX_W-1:0] slot_reg;

    // Position table, x in the upper half of a word and y in the lower half.
    logic [2*POS_W-1:0] pos_mem [ENTITIES];
    logic [2*POS_W-1:0] mem_rd_reg;
    logic               mem_we;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;

    // Working values of a step.
    mag_t   dx_reg;
    mag_t   dy_reg;
    mag_t   abs_x;
    mag_t   abs_y;
    prod_t  dsq_reg;
    logic   near;
    mag_t   step_reg;
    mag_t   step_next;
    mag_t   move_x;
    mag_t   move_y;
    mag_t   sum_x;
    mag_t   sum_y;
    logic [POS_W-1:0] res_x_reg;
    logic [POS_W-1:0] res_y_reg;
    logic   hit_reg;
    logic   fset_reg;
    logic   fleft_reg;

    // Serial units.
    logic       mul_start;
    mag_t       mul_a;
    mag_t       mul_b;
    prod_t      mul_prod;
    unit_stat_t mul_stat;
    logic       div_start;
    prod_t      div_num;
    mag_t       div_den;
    mag_t       div_quot;
    unit_stat_t div_stat;
    logic       sqrt_start;
    mag_t       sqrt_root;
    unit_stat_t sqrt_stat;

    // Output register.
    logic             finish_go;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ENT_W-1:0] entity_out_reg;
    logic [POS_W-1:0] new_x_reg;
    logic [POS_W-1:0] new_y_reg;
    logic             arrived_reg;
    logic             facing_set_reg;
    logic             facing_left_reg;

    vstt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .stat  (mul_stat)
    );

    vstt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    vstt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n     (dsq_reg),
        .root  (sqrt_root),
        .stat  (sqrt_stat)
    );

    assign px = mem_rd_reg[2*POS_W-1:POS_W];
    assign py = mem_rd_reg[POS_W-1:0];

    // The differences are kept in two's complement; bit MAG_W-1 is the sign.
    assign abs_x = dx_reg[MAG_W-1] ? ~dx_reg + 1'b1 : dx_reg;
    assign abs_y = dy_reg[MAG_W-1] ? ~dy_reg + 1'b1 : dy_reg;

    assign near = dsq_reg <= ARRIVE_SQ;

    // Step length is the travel distance clipped to the remaining distance.
    assign step_next = (div_quot > sqrt_root) ? sqrt_root : div_quot;

    // The quotient is a magnitude; restore the sign of the axis difference,
    // which truncates the signed movement toward zero.
    assign move_x = dx_reg[MAG_W-1] ? ~div_quot + 1'b1 : div_quot;
    assign move_y = dy_reg[MAG_W-1] ? ~div_quot + 1'b1 : div_quot;
    assign sum_x  = {px[POS_W-1], px} + move_x;
    assign sum_y  = {py[POS_W-1], py} + move_y;

    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign mem_we    = finish_go;

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = abs_x;
        mul_b      = abs_x;
        div_start  = 1'b0;
        div_num    = mul_prod;
        div_den    = sqrt_root;
        sqrt_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                state_next = (op_reg == OP_LOAD) ? S_FINISH : S_READ;
            end
            S_READ:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_SQX;
            end
            S_SQX:
            begin
                mul_start  = 1'b1;
                state_next = S_WSQX;
            end
            S_WSQX:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = abs_y;
                    mul_b      = abs_y;
                    state_next = S_WSQY;
                end
            end
            S_WSQY:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MAG_W'(speed_reg);
                    mul_b      = MAG_W'(ticks_reg);
                    state_next = S_WSPD;
                end
            end
            S_WSPD:
            begin
                if (mul_stat.done)
                begin
                    if (near)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_den    = MAG_W'(TICK_RATE);
                        sqrt_start = 1'b1;
                        state_next = S_WROOT;
                    end
                end
            end
            S_WROOT:
            begin
                if (div_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_b      = step_next;
                    state_next = S_WMX;
                end
            end
            S_WMX:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_WDX;
                end
            end
            S_WDX:
            begin
                if (div_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = abs_y;
                    mul_b      = step_reg;
                    state_next = S_WMY;
                end
            end
            S_WMY:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_WDY;
                end
            end
            S_WDY:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A finished result replaces the one in the output register, or fills it
    // when it is empty; otherwise the register drains when the receiver takes.
    always_comb
    begin
        if (finish_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture and the working registers of a step.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg    <= op;
            ent_reg   <= entity;
            tx_reg    <= target_x;
            ty_reg    <= target_y;
            speed_reg <= speed;
            ticks_reg <= ticks;
        end
        if (state_reg == S_INDEX)
        begin
            // A load returns the loaded position with all flags clear.
            slot_reg  <= entity_slot(ent_reg);
            res_x_reg <= tx_reg;
            res_y_reg <= ty_reg;
            hit_reg   <= 1'b0;
            fset_reg  <= 1'b0;
            fleft_reg <= 1'b0;
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= {tx_reg[POS_W-1], tx_reg} - {px[POS_W-1], px};
            dy_reg <= {ty_reg[POS_W-1], ty_reg} - {py[POS_W-1], py};
        end
        if (state_reg == S_WSQX && mul_stat.done)
        begin
            dsq_reg <= mul_prod;
        end
        if (state_reg == S_WSQY && mul_stat.done)
        begin
            dsq_reg <= dsq_reg + mul_prod;
        end
        if (state_reg == S_WSPD && mul_stat.done)
        begin
            if (near)
            begin
                // Within the arrival radius the entity snaps onto the target.
                res_x_reg <= tx_reg;
                res_y_reg <= ty_reg;
                hit_reg   <= 1'b1;
            end
            else
            begin
                fset_reg  <= abs_x > ONE_PIXEL;
                fleft_reg <= (abs_x > ONE_PIXEL) && dx_reg[MAG_W-1];
            end
        end
        if (state_reg == S_WROOT && div_stat.done)
        begin
            step_reg <= step_next;
        end
        if (state_reg == S_WDX && div_stat.done)
        begin
            res_x_reg <= sum_x[POS_W-1:0];
        end
        if (state_reg == S_WDY && div_stat.done)
        begin
            res_y_reg <= sum_y[POS_W-1:0];
        end
        if (finish_go)
        begin
            entity_out_reg  <= ent_reg;
            new_x_reg       <= res_x_reg;
            new_y_reg       <= res_y_reg;
            arrived_reg     <= hit_reg;
            facing_set_reg  <= fset_reg;
            facing_left_reg <= fleft_reg;
        end
    end

    // Position table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[slot_reg] <= {res_x_reg, res_y_reg};
        end
        if (state_reg == S_READ)
        begin
            mem_rd_reg <= pos_mem[slot_reg];
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign entity_out  = entity_out_reg;
    assign new_x       = new_x_reg;
    assign new_y       = new_y_reg;
    assign arrived     = arrived_reg;
    assign facing_set  = facing_set_reg;
    assign facing_left = facing_left_reg;

    // No serial unit is ever restarted while it still works.
    `VSTT_ASSERT_IMP(a_start_when_idle, clk, rst_n, mul_start || div_start || sqrt_start, !mul_stat.busy && !div_stat.busy && !sqrt_stat.busy)
    // The root and the travel distance are started together and finish together.
    `VSTT_ASSERT_IMP(a_root_with_quot, clk, rst_n, state_reg == S_WROOT && div_stat.done, sqrt_stat.done)
    // The step never overshoots the remaining distance.
    `VSTT_ASSERT_IMP(a_step_bounded, clk, rst_n, state_reg == S_WMX, step_reg <= sqrt_root)
    // The movement on an axis never exceeds the distance on that axis.
    `VSTT_ASSERT_IMP(a_move_bounded, clk, rst_n, state_reg == S_WDX && div_stat.done, div_quot <= abs_x)
    // Completing a request always leaves a result waiting and the block free.
    `VSTT_ASSERT_NEXT(a_finish_frees, clk, rst_n, finish_go, out_valid_reg && state_reg == S_IDLE)

endmodule
